FILE: rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list unit
// Operation codes, status codes, list capacity and the command broadcast
// from the control block to the row of storage cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int CAPACITY = 64;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = 7;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 2;

	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic              wr;
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  wpos;
		logic [WORD_W-1:0] wdata;
	} cell_cmd_t;

endpackage

FILE: rtl/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell: one storage cell of the list
// Holds one word; shifts from its left or right neighbor, loads the write
// word, or holds, and drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ilir_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  ilir_pkg::cell_cmd_t              cmd,
	input  logic [ilir_pkg::WORD_W-1:0]      left_word,
	input  logic [ilir_pkg::WORD_W-1:0]      right_word,
	output logic [ilir_pkg::WORD_W-1:0]      word,
	output logic [ilir_pkg::WORD_W-1:0]      rd_word
);

	localparam logic [ilir_pkg::IDX_W-1:0] IDX_V = ilir_pkg::IDX_W'(IDX);

	logic [ilir_pkg::WORD_W-1:0] word_q;
	logic [ilir_pkg::WORD_W-1:0] word_d;

	always_comb begin
		priority if (cmd.ins && IDX_V == cmd.pos) begin
			word_d = cmd.wdata;
		end else if (cmd.ins && IDX_V > cmd.pos) begin
			word_d = left_word;
		end else if (cmd.rem && IDX_V >= cmd.pos) begin
			word_d = right_word;
		end else if (cmd.wr && IDX_V == cmd.wpos) begin
			word_d = cmd.wdata;
		end else begin
			word_d = word_q;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word    = word_q;
	assign rd_word = (IDX_V == cmd.pos) ? word_q : '0;

endmodule

FILE: rtl/ilir_ctrl.sv
// ----------------------------------------------------------------------------
// ilir_ctrl: operation decode and length counter
// Checks the index and fill level, issues the cell command and keeps the
// number of valid entries.
// ----------------------------------------------------------------------------
module ilir_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [ilir_pkg::MODE_W-1:0]       mode,
	input  logic [ilir_pkg::IDX_W-1:0]        position,
	input  logic [ilir_pkg::WORD_W-1:0]       value,
	output ilir_pkg::cell_cmd_t               cmd,
	output logic [ilir_pkg::STAT_W-1:0]       status_d,
	output logic [ilir_pkg::IDX_W-1:0]        length_d,
	output logic                              rd_ok,
	output logic                              rd_bad
);

	localparam logic [ilir_pkg::IDX_W-1:0] CAP_V = ilir_pkg::IDX_W'(ilir_pkg::CAPACITY);

	logic [ilir_pkg::IDX_W-1:0] count_q;
	logic                       full;
	logic                       past_end;
	logic                       at_or_past_end;

	assign full           = (count_q >= CAP_V);
	assign past_end       = (position > count_q);
	assign at_or_past_end = (position >= count_q);

	always_comb begin
		cmd       = '0;
		cmd.pos   = position;
		cmd.wpos  = position;
		cmd.wdata = value;
		status_d  = ilir_pkg::ST_OK;
		length_d  = count_q;
		rd_ok     = 1'b0;
		rd_bad    = 1'b0;
		unique case (mode)
			ilir_pkg::MODE_APPEND: begin
				if (full) begin
					status_d = ilir_pkg::ST_FULL;
				end else begin
					cmd.wr   = accept;
					cmd.wpos = count_q;
					length_d = count_q + 1'b1;
				end
			end
			ilir_pkg::MODE_INSERT: begin
				priority if (past_end) begin
					status_d = ilir_pkg::ST_BOUNDS;
				end else if (full) begin
					status_d = ilir_pkg::ST_FULL;
				end else begin
					cmd.ins  = accept;
					length_d = count_q + 1'b1;
				end
			end
			ilir_pkg::MODE_READ: begin
				if (at_or_past_end) begin
					status_d = ilir_pkg::ST_BOUNDS;
					rd_bad   = 1'b1;
				end else begin
					rd_ok = 1'b1;
				end
			end
			ilir_pkg::MODE_REMOVE: begin
				if (at_or_past_end) begin
					status_d = ilir_pkg::ST_BOUNDS;
				end else begin
					cmd.rem  = accept;
					length_d = count_q - 1'b1;
				end
			end
			ilir_pkg::MODE_REPLACE: begin
				if (at_or_past_end) begin
					status_d = ilir_pkg::ST_BOUNDS;
				end else begin
					cmd.wr = accept;
				end
			end
			ilir_pkg::MODE_CLEAR: begin
				length_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= length_d;
		end
	end

endmodule

FILE: rtl/indexed_list_insert_remove_unit.sv
// done strobes in the cycle after start is taken.
// Throughput: one operation per cycle; every cell shifts or loads in parallel,
// so insert and remove take no longer than append or read.
// busy stays low; the receiver cannot stall and takes each result as shown.
// Reset clears the length counter and the result strobe; stored words and result registers are unset.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_unit: ordered list of words with indexed edits
// A row of word cells under one control block; supports append, insert,
// read, remove, replace and clear, each returning status and length.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ilir_pkg::MODE_W-1:0]     mode,
	input  logic [ilir_pkg::IDX_W-1:0]      position,
	input  logic signed [ilir_pkg::WORD_W-1:0] value,
	output logic                            done,
	output logic signed [ilir_pkg::WORD_W-1:0] read_value,
	output logic [ilir_pkg::STAT_W-1:0]     status,
	output logic [ilir_pkg::IDX_W-1:0]      length
);

	localparam int N = ilir_pkg::CAPACITY;

	ilir_pkg::cell_cmd_t         cmd;
	logic [ilir_pkg::STAT_W-1:0] status_d;
	logic [ilir_pkg::IDX_W-1:0]  length_d;
	logic                        rd_ok;
	logic                        rd_bad;
	logic                        accept;

	logic [ilir_pkg::WORD_W-1:0] words   [N];
	logic [ilir_pkg::WORD_W-1:0] rd_words[N];
	logic [ilir_pkg::WORD_W-1:0] rd_bus;
	logic [ilir_pkg::WORD_W-1:0] read_d;

	logic                        done_q;
	logic [ilir_pkg::WORD_W-1:0] read_value_q;
	logic [ilir_pkg::STAT_W-1:0] status_q;
	logic [ilir_pkg::IDX_W-1:0]  length_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ilir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (mode),
		.position (position),
		.value    (value),
		.cmd      (cmd),
		.status_d (status_d),
		.length_d (length_d),
		.rd_ok    (rd_ok),
		.rd_bad   (rd_bad)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		ilir_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_word  (words[(i == 0) ? 0 : i - 1]),
			.right_word (words[(i == N - 1) ? N - 1 : i + 1]),
			.word       (words[i]),
			.rd_word    (rd_words[i])
		);
	end

	// only the addressed cell drives a nonzero word
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < N; i++) begin
			rd_bus = rd_bus | rd_words[i];
		end
	end

	always_comb begin
		priority if (rd_ok) begin
			read_d = rd_bus;
		end else if (rd_bad) begin
			read_d = '1;
		end else begin
			read_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_d;
			status_q     <= status_d;
			length_q     <= length_d;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result word without a taken command");

	a_length_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (length <= ilir_pkg::IDX_W'(ilir_pkg::CAPACITY)))
		else $error("length beyond capacity");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ilir_pkg::ST_FULL) |->
			(length == ilir_pkg::IDX_W'(ilir_pkg::CAPACITY)))
		else $error("full status below capacity");

	a_bounds_keeps_length: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && status == ilir_pkg::ST_BOUNDS) |->
			(length == $past(length)))
		else $error("length changed on bad index");
`endif

endmodule
